@@ design/mbd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, sizes and helpers of the multichannel boxcar averager.
// Used by the channel interfaces and the top level; depends on nothing.
package mbd_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int FILTER_POWER = 6;

  localparam int CH_W       = 3;
  localparam int SMP_W      = 10;
  localparam int SUM_W      = 16;
  localparam int JIT_W      = 4;
  localparam int TIME_W     = 32;
  localparam int RING_LEN   = 1 << FILTER_POWER;
  localparam int RING_DEPTH = NUM_CHANNELS * RING_LEN;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int HALF_STEP  = 1 << (FILTER_POWER - 1);

  typedef logic [CH_W-1:0]         chan_t;
  typedef logic [SMP_W-1:0]        sample_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic [JIT_W-1:0]        jitter_t;
  typedef logic [TIME_W-1:0]       stamp_t;
  typedef logic [FILTER_POWER-1:0] slot_t;
  typedef logic [RING_AW-1:0]      ring_addr_t;

  localparam logic [CH_W:0]    NUM_CH_L    = (CH_W + 1)'(NUM_CHANNELS);
  localparam ring_addr_t       RING_LAST   = RING_AW'(RING_DEPTH - 1);
  localparam slot_t            SLOT_LAST   = '1;
  localparam sum_t             HALF_STEP_S = SUM_W'(HALF_STEP);

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_PRELOAD = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_TRACKED_CHANNEL = 1'b0,
    CFG_JITTER_RANGE    = 1'b1
  } cfg_idx_t;

  function automatic sample_t filtered_of(input sum_t s);
    sum_t sh;
    sh = s >> FILTER_POWER;
    return sh[SMP_W-1:0];
  endfunction

  function automatic logic chan_ok(input chan_t c);
    return {1'b0, c} < NUM_CH_L;
  endfunction

endpackage

@@ design/mbd_if.sv @@
`timescale 1ns / 1ps
// Request channel interfaces of the boxcar averager: sample input and result output.
// Depends on mbd_pkg for the payload types.
interface mbd_in_if import mbd_pkg::*; ();
  logic    valid;
  logic    ready;
  cmd_t    cmd;
  chan_t   preload_channel;
  sample_t sample;
  stamp_t  uptime;

  modport source (output valid, cmd, preload_channel, sample, uptime, input ready);
  modport sink   (input valid, cmd, preload_channel, sample, uptime, output ready);
endinterface

interface mbd_out_if import mbd_pkg::*; ();
  logic    valid;
  logic    ready;
  chan_t   out_channel;
  sample_t filtered_value;
  sample_t tracked_level;
  stamp_t  tracked_stamp;
  logic    tracked_changed;

  modport source (output valid, out_channel, filtered_value, tracked_level, tracked_stamp,
                  tracked_changed, input ready);
  modport sink   (input valid, out_channel, filtered_value, tracked_level, tracked_stamp,
                  tracked_changed, output ready);
endinterface

@@ design/multichannel_boxcar_with_deadband.sv @@
`timescale 1ns / 1ps
// Top level of the multichannel boxcar averager with deadband tracker.
// Depends on mbd_pkg and the request interfaces in mbd_if.
//
// Usage: requests arrive on in_ch (valid/ready). A sample request updates the
// channel at the scan position; a preload request fills one channel's ring.
// Each request yields exactly one result on out_ch, held in an output register.
// Registers tracked_channel (index 0) and jitter_range (index 1) are written
// through cfg_we/cfg_index/cfg_wdata; the user must write them only while the
// block is idle, which the block does not enforce. For a sample request the
// ring memory is read in the accept cycle; the read-modify-write of ring and
// sum happens in the update state once the output register is free, and the
// result is registered with it. A preload fills all 64 ring entries of its
// channel through the single ring write port, none for a channel out of range.
// After reset the ring memory's 384 entries are cleared one entry per cycle,
// during which no request is accepted; configuration writes are still taken.
// A new request may be accepted while a result waits; if the receiver stalls,
// the update is held until the output register is free.
module multichannel_boxcar_with_deadband import mbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  jitter_t   cfg_wdata,
  mbd_in_if.sink    in_ch,
  mbd_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_UPD   = 5'b00100,
    S_FILL  = 5'b01000,
    S_PFIN  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  ring_addr_t cnt_r, cnt_nxt;
  chan_t      scan_r, scan_nxt;
  slot_t      slot_r, slot_nxt;
  sample_t    tv_r, tv_nxt;
  stamp_t     tt_r, tt_nxt;
  chan_t      trk_ch_r;
  jitter_t    jit_r;
  sum_t       sums_r [NUM_CHANNELS];

  chan_t      ch_r, pch_r;
  sample_t    smp_r;
  stamp_t     now_r;

  sample_t    ring_mem [RING_DEPTH];
  sample_t    ring_rd_r;

  logic       out_valid_r, out_valid_nxt;
  chan_t      out_chan_r, out_chan_nxt;
  sample_t    out_filt_r, out_filt_nxt;
  sample_t    out_lvl_r, out_lvl_nxt;
  stamp_t     out_stamp_r, out_stamp_nxt;
  logic       out_chg_r, out_chg_nxt;

  logic       in_acc, out_free, commit, out_load;
  chan_t      norm_ch, sum_sel;
  sum_t       sum_rd, new_sum, pre_sum;
  sample_t    v_new, v_pre, seed;
  logic       pch_ok, lower, raise, chg;
  logic       ring_we;
  ring_addr_t ring_waddr, ring_raddr;
  sample_t    ring_wdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign commit      = out_free && ((state_r == S_UPD) || (state_r == S_PFIN));
  assign out_load    = commit;

  assign norm_ch    = chan_ok(scan_r) ? scan_r : '0;
  assign ring_raddr = ring_addr_t'({norm_ch, slot_r});

  assign sum_sel = (state_r == S_PFIN) ? trk_ch_r : ch_r;
  assign sum_rd  = chan_ok(sum_sel) ? sums_r[sum_sel] : '0;
  assign new_sum = sum_rd - sum_t'(ring_rd_r) + sum_t'(smp_r);
  assign v_new   = filtered_of(new_sum);
  assign pre_sum = (sum_t'(smp_r) << FILTER_POWER) + HALF_STEP_S;
  assign v_pre   = filtered_of(pre_sum);
  assign pch_ok  = chan_ok(pch_r);

  assign lower = v_new < tv_r;
  assign raise = {1'b0, v_new} > ({1'b0, tv_r} + (SMP_W + 1)'(jit_r));
  assign chg   = (ch_r == trk_ch_r) && (lower || raise);

  always_comb begin
    if (!chan_ok(trk_ch_r)) begin
      seed = tv_r;
    end else if (pch_ok && (trk_ch_r == pch_r)) begin
      seed = v_pre;
    end else begin
      seed = filtered_of(sum_rd);
    end
  end

  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = cnt_r;
    ring_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        ring_we = 1'b1;
      end
      S_FILL: begin
        ring_we    = 1'b1;
        ring_waddr = ring_addr_t'({pch_r, cnt_r[FILTER_POWER-1:0]});
        ring_wdata = smp_r;
      end
      S_UPD: begin
        ring_we    = out_free;
        ring_waddr = ring_addr_t'({ch_r, slot_r});
        ring_wdata = smp_r;
      end
      default: begin
        ring_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    scan_nxt      = scan_r;
    slot_nxt      = slot_r;
    tv_nxt        = tv_r;
    tt_nxt        = tt_r;
    out_chan_nxt  = out_chan_r;
    out_filt_nxt  = out_filt_r;
    out_lvl_nxt   = out_lvl_r;
    out_stamp_nxt = out_stamp_r;
    out_chg_nxt   = out_chg_r;
    case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RING_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          if (in_ch.cmd == CMD_PRELOAD) begin
            state_nxt = chan_ok(in_ch.preload_channel) ? S_FILL : S_PFIN;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_FILL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[FILTER_POWER-1:0] == SLOT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_PFIN;
        end
      end
      S_UPD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (chg) begin
            tv_nxt = lower ? v_new : (v_new - sample_t'(jit_r));
            tt_nxt = now_r;
          end
          if (({1'b0, ch_r} + 1'b1) >= NUM_CH_L) begin
            scan_nxt = '0;
            slot_nxt = slot_r + 1'b1;
          end else begin
            scan_nxt = ch_r + 1'b1;
          end
          out_chan_nxt  = ch_r;
          out_filt_nxt  = v_new;
          out_lvl_nxt   = chg ? tv_nxt : tv_r;
          out_stamp_nxt = chg ? now_r : tt_r;
          out_chg_nxt   = chg;
        end
      end
      S_PFIN: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          scan_nxt      = '0;
          slot_nxt      = '0;
          tv_nxt        = seed;
          out_chan_nxt  = pch_r;
          out_filt_nxt  = pch_ok ? v_pre : '0;
          out_lvl_nxt   = seed;
          out_stamp_nxt = tt_r;
          out_chg_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      scan_r      <= '0;
      slot_r      <= '0;
      tv_r        <= '0;
      tt_r        <= '0;
      trk_ch_r    <= '0;
      jit_r       <= jitter_t'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      slot_r      <= slot_nxt;
      tv_r        <= tv_nxt;
      tt_r        <= tt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRACKED_CHANNEL: trk_ch_r <= cfg_wdata[CH_W-1:0];
          CFG_JITTER_RANGE:    jit_r    <= cfg_wdata;
          default:             jit_r    <= jit_r;
        endcase
      end
      if (commit && (state_r == S_UPD)) begin
        sums_r[ch_r] <= new_sum;
      end else if (commit && (state_r == S_PFIN) && pch_ok) begin
        sums_r[pch_r] <= pre_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r  <= norm_ch;
      pch_r <= in_ch.preload_channel;
      smp_r <= in_ch.sample;
      now_r <= in_ch.uptime;
    end
    if (out_load) begin
      out_chan_r  <= out_chan_nxt;
      out_filt_r  <= out_filt_nxt;
      out_lvl_r   <= out_lvl_nxt;
      out_stamp_r <= out_stamp_nxt;
      out_chg_r   <= out_chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.cmd == CMD_SAMPLE)) begin
      ring_rd_r <= ring_mem[ring_raddr];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_channel     = out_chan_r;
  assign out_ch.filtered_value  = out_filt_r;
  assign out_ch.tracked_level   = out_lvl_r;
  assign out_ch.tracked_stamp   = out_stamp_r;
  assign out_ch.tracked_changed = out_chg_r;

  a_sample_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.cmd == CMD_SAMPLE)) |=> (state_r == S_UPD))
    else $error("sample request did not move to the update step");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    chan_ok(scan_r))
    else $error("scan position outside the channel count");

  a_change_moves_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_chg_nxt) |=> (tv_r != $past(tv_r)))
    else $error("reported level change without a new level");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ring_we)
    else $error("ring memory written while idle");

  a_load_frees_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("result overwritten while the receiver stalls");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for multichannel_boxcar_with_deadband: predicts every result
// from its own model of the rings, sums and deadband tracker and checks them in order.
// Depends on mbd_pkg, the request interfaces in mbd_if and the top level of the block.
module tb_top;
  import mbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int END_SETTLE     = 70;

  typedef struct packed {
    chan_t   ch;
    sample_t mean;
    sample_t level;
    stamp_t  stamp;
    logic    moved;
  } boxcar_result_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  jitter_t  cfg_wdata;

  mbd_in_if  in_ch ();
  mbd_out_if out_ch ();

  multichannel_boxcar_with_deadband u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #4 clk = ~clk;

  sample_t        ring_model [RING_DEPTH];
  sum_t           sum_model [NUM_CHANNELS];
  int unsigned    scan_pos;
  int unsigned    slot_pos;
  int unsigned    level_model;
  stamp_t         stamp_model;
  int unsigned    track_sel;
  int unsigned    jitter_sel;
  boxcar_result_t pending_results [$];
  boxcar_result_t oldest;

  int     mismatches;
  int     idle_cycles;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_off_left;
  stamp_t uptime_now;

  initial begin
    foreach (ring_model[i]) ring_model[i] = '0;
    foreach (sum_model[i]) sum_model[i] = '0;
    scan_pos    = 0;
    slot_pos    = 0;
    level_model = 0;
    stamp_model = '0;
    track_sel   = 0;
    jitter_sel  = 1;
  end

  function automatic sample_t channel_mean(int unsigned ch);
    if (ch >= NUM_CHANNELS) return '0;
    return sample_t'(sum_model[ch] >> FILTER_POWER);
  endfunction

  task automatic predict_boxcar(input cmd_t c, input chan_t p, input sample_t s,
                                input stamp_t t);
    boxcar_result_t r;
    int unsigned    ch;
    int unsigned    pos;
    int unsigned    v;
    logic           moved;
    moved = 1'b0;
    if (c == CMD_PRELOAD) begin
      ch = p;
      if (p < NUM_CHANNELS) begin
        for (int i = 0; i < RING_LEN; i++) ring_model[p * RING_LEN + i] = s;
        sum_model[p] = sum_t'((32'(s) << FILTER_POWER) + HALF_STEP);
      end
      scan_pos = 0;
      slot_pos = 0;
      if (track_sel < NUM_CHANNELS) level_model = channel_mean(track_sel);
    end else begin
      ch  = scan_pos;
      pos = ch * RING_LEN + slot_pos;
      sum_model[ch] = sum_model[ch] - sum_t'(ring_model[pos]) + sum_t'(s);
      ring_model[pos] = s;
      if (ch == track_sel) begin
        v = channel_mean(ch);
        if (v < level_model) begin
          level_model = v;
          stamp_model = t;
          moved = 1'b1;
        end else if (v > level_model + jitter_sel) begin
          level_model = v - jitter_sel;
          stamp_model = t;
          moved = 1'b1;
        end
      end
      scan_pos = ch + 1;
      if (scan_pos >= NUM_CHANNELS) begin
        scan_pos = 0;
        slot_pos = (slot_pos + 1) % RING_LEN;
      end
    end
    r.ch    = chan_t'(ch);
    r.mean  = channel_mean(ch);
    r.level = sample_t'(level_model);
    r.stamp = stamp_model;
    r.moved = moved;
    pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      predict_boxcar(in_ch.cmd, in_ch.preload_channel, in_ch.sample, in_ch.uptime);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("out_channel: expected no result, got %0d", out_ch.out_channel);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("out_channel", oldest.ch, out_ch.out_channel);
        check_field("filtered_value", oldest.mean, out_ch.filtered_value);
        check_field("tracked_level", oldest.level, out_ch.tracked_level);
        check_field("tracked_stamp", oldest.stamp, out_ch.tracked_stamp);
        check_field("tracked_changed", oldest.moved, out_ch.tracked_changed);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_request(input cmd_t c, input chan_t p, input sample_t s,
                              input stamp_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= c;
    in_ch.preload_channel <= p;
    in_ch.sample          <= s;
    in_ch.uptime          <= t;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_until_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input chan_t tc, input jitter_t jr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRACKED_CHANNEL;
    cfg_wdata <= {1'($urandom_range(1)), tc};
    @(posedge clk);
    cfg_index <= CFG_JITTER_RANGE;
    cfg_wdata <= jr;
    @(posedge clk);
    cfg_we     <= 1'b0;
    track_sel  = tc;
    jitter_sel = jr;
  endtask

  task automatic set_idling(input int mode);
    int send_modes [4] = '{0, 66, 0, 6};
    int recv_modes [4] = '{0, 0, 66, 6};
    send_idle_pct  = send_modes[mode % 4];
    recv_stall_pct = recv_modes[mode % 4];
  endtask

  function automatic int clamp_sample(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // Samples mostly follow a drifting level, so that channel means ramp up and down
  // through the deadband; some requests are wide noise and some are preloads.
  task automatic stream_requests(input int count, input int preload_pct);
    int    base;
    int    roll;
    chan_t pch;
    base = $urandom_range(1023);
    repeat (count) begin
      roll = $urandom_range(99);
      if ($urandom_range(49) == 0) begin
        case ($urandom_range(2))
          0: base = 0;
          1: base = 1023;
          default: base = $urandom_range(1023);
        endcase
      end else begin
        base = clamp_sample(base + int'($urandom_range(24)) - 12);
      end
      if ($urandom_range(29) == 0) uptime_now = $urandom();
      else uptime_now = uptime_now + $urandom_range(1, 999);
      if (roll < preload_pct) begin
        pch = ($urandom_range(9) == 0) ? chan_t'($urandom_range(7, 6))
                                        : chan_t'($urandom_range(NUM_CHANNELS - 1));
        send_request(CMD_PRELOAD, pch, sample_t'(base), uptime_now);
      end else if (roll < preload_pct + 10) begin
        send_request(CMD_SAMPLE, chan_t'($urandom_range(7)),
                     sample_t'($urandom_range(1023)), uptime_now);
      end else begin
        send_request(CMD_SAMPLE, chan_t'($urandom_range(7)),
                     sample_t'(clamp_sample(base + int'($urandom_range(6)) - 3)),
                     uptime_now);
      end
    end
  endtask

  task automatic test_directed_edges();
    set_idling(0);
    send_request(CMD_SAMPLE, 3'd7, 10'd1023, 32'h0000_0000);
    send_request(CMD_SAMPLE, 3'd0, 10'd0, 32'hFFFF_FFFF);
    send_request(CMD_SAMPLE, 3'd5, 10'd1023, 32'h0000_0001);
    send_request(CMD_SAMPLE, 3'd2, 10'd512, 32'h8000_0000);
    send_request(CMD_SAMPLE, 3'd1, 10'd1, 32'h7FFF_FFFF);
    send_request(CMD_SAMPLE, 3'd6, 10'd1022, 32'h0000_0010);
    send_request(CMD_PRELOAD, 3'd0, 10'd1023, 32'hFFFF_FFFF);
    send_request(CMD_SAMPLE, 3'd0, 10'd0, 32'h1234_5678);
    send_request(CMD_PRELOAD, 3'd5, 10'd0, 32'h0000_0020);
    send_request(CMD_PRELOAD, 3'd6, 10'd700, 32'h0000_0030);
    send_request(CMD_PRELOAD, 3'd7, 10'd1023, 32'h0000_0040);
    send_request(CMD_PRELOAD, 3'd3, 10'd1023, 32'h0000_0050);
    send_request(CMD_PRELOAD, 3'd0, 10'd0, 32'h0000_0060);
    for (int i = 0; i < 12; i++)
      send_request(CMD_SAMPLE, chan_t'(i), (i % 2 == 0) ? 10'd1023 : 10'd0,
                   (i % 2 == 0) ? 32'h5555_5555 : 32'hAAAA_AAAA);
  endtask

  task automatic test_config_sweep();
    chan_t   tc_list [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd2, 3'd4, 3'd0, 3'd5};
    jitter_t jr_list [8] = '{4'd0, 4'd15, 4'd7, 4'd1, 4'd4, 4'd15, 4'd15, 4'd0};
    int      pct_list [8] = '{0, 0, 4, 1, 0, 0, 4, 2};
    for (int i = 0; i < 8; i++) begin
      wait_until_idle();
      set_config(tc_list[i], jr_list[i]);
      set_idling(i);
      stream_requests(200, pct_list[i]);
    end
  endtask

  task automatic test_tracker_disabled();
    wait_until_idle();
    set_config(3'd6, 4'd3);
    set_idling(1);
    stream_requests(120, 10);
    wait_until_idle();
    set_config(3'd7, 4'd0);
    set_idling(2);
    stream_requests(60, 10);
  endtask

  task automatic test_output_backpressure();
    wait_until_idle();
    set_config(3'd2, 4'd2);
    set_idling(0);
    hold_off_left = 300;
    stream_requests(60, 0);
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_TRACKED_CHANNEL;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.cmd             = CMD_SAMPLE;
    in_ch.preload_channel = '0;
    in_ch.sample          = '0;
    in_ch.uptime          = '0;
    out_ch.ready          = 1'b0;
    mismatches            = 0;
    idle_cycles           = 0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    hold_off_left         = 0;
    uptime_now            = $urandom();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_config_sweep();
    test_tracker_disabled();
    test_output_backpressure();
    wait_until_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
